// ===== rtl/tgsv_pkg.sv =====
// Shared types, constants and helpers for the group-statistics varint encoder.
`default_nettype none

package tgsv_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned GROUP_W     = 32;
    localparam int unsigned DIGIT_W     = 7;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_TERM  = 2'd0;
    localparam logic [1:0] OP_GROUP = 2'd1;
    localparam logic [1:0] OP_STAT  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    typedef struct packed {
        logic                cont_first;
        logic                has_second;
        logic [WORD_W-1:0]   first_val;
        logic [WORD_W-1:0]   second_val;
    } job_t;

    function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] v);
        return {v[WORD_W-2:0], 1'b0} ^ {WORD_W{v[WORD_W-1]}};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/term_group_stats_varint_encoder_unit.sv =====
// Top level: group-statistics LEB128 varint encoder with decoupled front and back ends.
// An item is queued, loaded into the serializer, and its bytes enter the output register.
// Throughput: one output byte per cycle unless out_ready stalls it; bytes per item:
// header 2..20, group 1..5, stat 1..10, end 1. The byte serializer sets this rate.
// Reset: rst_n asynchronous, active low; previous term and group become minus one,
// queue and output register empty.
`default_nettype none

module term_group_stats_varint_encoder_unit
#(
    parameter int unsigned QUEUE_DEPTH = tgsv_pkg::QUEUE_DEPTH
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            operation,
    input  wire logic signed [tgsv_pkg::WORD_W-1:0]    value,
    input  wire logic signed [tgsv_pkg::WORD_W-1:0]    doc_freq,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [tgsv_pkg::BYTE_W-1:0]                out_byte,
    output logic                                       last
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

    tgsv_pkg::job_t   push_job;
    tgsv_pkg::job_t   head_job;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;
    logic [CNT_W-1:0] q_count;

    tgsv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .value     (value),
        .doc_freq  (doc_freq),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    tgsv_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .pop       (q_pop),
        .head_job  (head_job),
        .full      (q_full),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    tgsv_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

`ifndef SYNTH
    a_last_is_final_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !out_byte[tgsv_pkg::BYTE_W-1])
        else $error("last flagged on a continuation byte");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_count == '0 |-> !q_pop)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/tgsv_front.sv =====
// Front end: accept items, track previous term and group, build varint jobs.
`default_nettype none

module tgsv_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   operation,
    input  wire logic signed [tgsv_pkg::WORD_W-1:0] value,
    input  wire logic signed [tgsv_pkg::WORD_W-1:0] doc_freq,
    input  wire logic                         q_full,
    output logic                              q_push,
    output tgsv_pkg::job_t                    q_job
);

    logic [tgsv_pkg::WORD_W-1:0]  prev_term_reg;
    logic [tgsv_pkg::WORD_W-1:0]  prev_term_next;
    logic [tgsv_pkg::GROUP_W-1:0] prev_group_reg;
    logic [tgsv_pkg::GROUP_W-1:0] prev_group_next;
    logic [tgsv_pkg::WORD_W-1:0]  val_u;
    logic [tgsv_pkg::GROUP_W-1:0] group_id;
    logic [tgsv_pkg::GROUP_W-1:0] group_delta;
    logic [tgsv_pkg::WORD_W-1:0]  term_delta;
    logic                         accept;

    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;
    assign q_push      = accept;
    assign val_u       = value;
    assign group_id    = val_u[tgsv_pkg::GROUP_W-1:0];
    assign group_delta = group_id - prev_group_reg;
    assign term_delta  = val_u - prev_term_reg;

    always_comb
    begin
        q_job.cont_first = 1'b0;
        q_job.has_second = 1'b0;
        q_job.first_val  = '0;
        q_job.second_val = tgsv_pkg::zigzag(doc_freq);
        prev_term_next   = prev_term_reg;
        prev_group_next  = prev_group_reg;
        case (operation)
            tgsv_pkg::OP_TERM:
            begin
                // both minus one: non-canonical zero, delta is zero anyway
                q_job.cont_first = (&prev_term_reg) && (&val_u);
                q_job.has_second = 1'b1;
                q_job.first_val  = term_delta;
                prev_term_next   = val_u;
                prev_group_next  = '1;
            end
            tgsv_pkg::OP_GROUP:
            begin
                q_job.first_val = {{(tgsv_pkg::WORD_W-tgsv_pkg::GROUP_W){1'b0}}, group_delta};
                prev_group_next = group_id;
            end
            tgsv_pkg::OP_STAT:
            begin
                q_job.first_val = tgsv_pkg::zigzag(val_u);
            end
            tgsv_pkg::OP_END:
            begin
                q_job.first_val = '0;
            end
            default:
            begin
                q_job.first_val = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_term_reg  <= '1;
            prev_group_reg <= '1;
        end
        else if (accept)
        begin
            prev_term_reg  <= prev_term_next;
            prev_group_reg <= prev_group_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tgsv_queue.sv =====
// Short job queue between the front end and the byte serializer.
`default_nettype none

module tgsv_queue
#(
    parameter int unsigned DEPTH = tgsv_pkg::QUEUE_DEPTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire tgsv_pkg::job_t             push_job,
    input  wire logic                       pop,
    output tgsv_pkg::job_t                  head_job,
    output logic                            full,
    output logic                            not_empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH+1);

    tgsv_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign head_job  = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tgsv_back.sv =====
// Back end: one varint byte per cycle into the output register unless stalled.
`default_nettype none

module tgsv_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_not_empty,
    input  wire tgsv_pkg::job_t       q_job,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [tgsv_pkg::BYTE_W-1:0] out_byte,
    output logic                      last
);

    localparam int unsigned W  = tgsv_pkg::WORD_W;
    localparam int unsigned DW = tgsv_pkg::DIGIT_W;

    logic                      busy_reg;
    logic                      busy_next;
    logic                      cont_reg;
    logic                      cont_next;
    logic                      pend_reg;
    logic                      pend_next;
    logic [W-1:0]              cur_reg;
    logic [W-1:0]              cur_next;
    logic [W-1:0]              second_reg;
    logic [W-1:0]              second_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [tgsv_pkg::BYTE_W-1:0] out_byte_reg;
    logic                      last_reg;
    logic                      more;
    logic                      advance;
    logic                      finish;
    logic                      load;

    assign more    = (cur_reg[W-1:DW] != '0) || cont_reg;
    assign advance = busy_reg && (!out_valid_reg || out_ready);
    assign finish  = advance && !more && !pend_reg;
    assign load    = q_not_empty && (!busy_reg || finish);
    assign q_pop   = load;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        cont_next   = cont_reg;
        pend_next   = pend_reg;
        cur_next    = cur_reg;
        second_next = second_reg;
        if (load)
        begin
            busy_next   = 1'b1;
            cont_next   = q_job.cont_first;
            pend_next   = q_job.has_second;
            cur_next    = q_job.first_val;
            second_next = q_job.second_val;
        end
        else if (advance)
        begin
            if (more)
            begin
                cur_next  = cur_reg >> DW;
                cont_next = 1'b0;
            end
            else if (pend_reg)
            begin
                cur_next  = second_reg;
                pend_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cont_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cont_reg      <= cont_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        second_reg <= second_next;
        if (advance)
        begin
            out_byte_reg <= {more, cur_reg[DW-1:0]};
            last_reg     <= !more && !pend_reg;
        end
    end

endmodule

`default_nettype wire

// ===== verif/term_group_stats_varint_encoder_unit_tb.sv =====
// Self-checking testbench for the group-statistics varint encoder: byte stream vs. predictor.
`default_nettype none

module term_group_stats_varint_encoder_unit_tb;

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned PHASE_ITEMS  = 90;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        logic [tgsv_pkg::BYTE_W-1:0] data;
        logic                        tail;
    } enc_byte_t;

    class varint_stream_scoreboard;
        logic [tgsv_pkg::WORD_W-1:0]  prior_term;
        logic [tgsv_pkg::GROUP_W-1:0] prior_group;
        enc_byte_t                    pending_bytes[$];
        int unsigned                  mismatches;

        function new();
            prior_term  = '1;
            prior_group = '1;
            mismatches  = 0;
        endfunction

        function void push_byte(logic [tgsv_pkg::BYTE_W-1:0] data);
            enc_byte_t b;
            b.data = data;
            b.tail = 1'b0;
            pending_bytes.push_back(b);
        endfunction

        function void push_varint(logic [tgsv_pkg::WORD_W-1:0] v);
            while (v >= 64'h80)
            begin
                push_byte({1'b1, v[6:0]});
                v = v >> tgsv_pkg::DIGIT_W;
            end
            push_byte(v[tgsv_pkg::BYTE_W-1:0]);
        endfunction

        function logic [tgsv_pkg::WORD_W-1:0] fold_sign(logic [tgsv_pkg::WORD_W-1:0] v);
            return (v << 1) ^ {tgsv_pkg::WORD_W{v[tgsv_pkg::WORD_W-1]}};
        endfunction

        function void note_item(logic [1:0] op, logic [tgsv_pkg::WORD_W-1:0] val,
                                logic [tgsv_pkg::WORD_W-1:0] freq);
            logic [tgsv_pkg::GROUP_W-1:0] gap;
            case (op)
                tgsv_pkg::OP_TERM:
                begin
                    if (prior_term == '1 && val == '1)
                    begin
                        push_byte(8'h80);
                        push_byte(8'h00);
                    end
                    else
                        push_varint(val - prior_term);
                    prior_term = val;
                    push_varint(fold_sign(freq));
                    prior_group = '1;
                end
                tgsv_pkg::OP_GROUP:
                begin
                    gap = val[tgsv_pkg::GROUP_W-1:0] - prior_group;
                    push_varint({{(tgsv_pkg::WORD_W-tgsv_pkg::GROUP_W){1'b0}}, gap});
                    prior_group = val[tgsv_pkg::GROUP_W-1:0];
                end
                tgsv_pkg::OP_STAT:
                    push_varint(fold_sign(val));
                default:
                    push_byte(8'h00);
            endcase
            pending_bytes[pending_bytes.size()-1].tail = 1'b1;
        endfunction

        function void check_byte(logic [tgsv_pkg::BYTE_W-1:0] got_byte, logic got_tail);
            enc_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected byte %02h last %0b", got_byte, got_tail);
                return;
            end
            want = pending_bytes.pop_front();
            if (want.data !== got_byte || want.tail !== got_tail)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                             want.data, want.tail, got_byte, got_tail);
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic [1:0]                         operation;
    logic signed [tgsv_pkg::WORD_W-1:0] value;
    logic signed [tgsv_pkg::WORD_W-1:0] doc_freq;
    logic                               out_valid;
    logic                               out_ready;
    logic [tgsv_pkg::BYTE_W-1:0]        out_byte;
    logic                               last;

    varint_stream_scoreboard sb = new();

    int unsigned                 src_idle_pct;
    int unsigned                 snk_idle_pct;
    bit                          hold_off_pending;
    int unsigned                 items_sent;
    logic [tgsv_pkg::WORD_W-1:0] next_term;
    int unsigned                 quiet_cycles;

    term_group_stats_varint_encoder_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .value     (value),
        .doc_freq  (doc_freq),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [tgsv_pkg::WORD_W-1:0] rand_word();
        logic [tgsv_pkg::WORD_W-1:0] w;
        int unsigned                 nbits;
        w     = {$urandom, $urandom};
        nbits = $urandom_range(1, 64);
        if (nbits < 64)
            w = w & ((64'd1 << nbits) - 64'd1);
        if ($urandom_range(0, 3) == 0)
            w = ~w;
        return w;
    endfunction

    task automatic send_item(logic [1:0] op, logic [tgsv_pkg::WORD_W-1:0] val,
                             logic [tgsv_pkg::WORD_W-1:0] freq);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        doc_freq  <= freq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(op, val, freq);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_record();
        logic [tgsv_pkg::WORD_W-1:0]  term_val;
        logic [tgsv_pkg::GROUP_W-1:0] grp;
        int unsigned                  n_groups;
        if ($urandom_range(0, 3) == 0)
            term_val = rand_word();
        else
            term_val = next_term + 64'($urandom_range(1, 3000));
        next_term = term_val;
        send_item(tgsv_pkg::OP_TERM, term_val, rand_word());
        grp      = $urandom_range(0, 50);
        n_groups = $urandom_range(0, 4);
        repeat (n_groups)
        begin
            send_item(tgsv_pkg::OP_GROUP, {$urandom, grp}, {$urandom, $urandom});
            repeat ($urandom_range(1, 3))
                send_item(tgsv_pkg::OP_STAT, rand_word(), {$urandom, $urandom});
            grp = grp + (($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 500));
        end
        if ($urandom_range(0, 7) != 0)
            send_item(tgsv_pkg::OP_END, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_byte(out_byte, last);
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_pending = 1'b0;
            end
            out_ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        operation        = tgsv_pkg::OP_TERM;
        value            = '0;
        doc_freq         = '0;
        src_idle_pct     = 21;
        snk_idle_pct     = 75;
        hold_off_pending = 1'b0;
        items_sent       = 0;
        next_term        = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(tgsv_pkg::OP_TERM,  64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(tgsv_pkg::OP_TERM,  64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_item(tgsv_pkg::OP_GROUP, 64'h0,                   64'hFFFF_FFFF_FFFF_FFFF);
        send_item(tgsv_pkg::OP_GROUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(tgsv_pkg::OP_GROUP, 64'h0,                   64'h0);
        send_item(tgsv_pkg::OP_STAT,  64'h0,                   64'h0);
        send_item(tgsv_pkg::OP_STAT,  64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(tgsv_pkg::OP_STAT,  64'h7FFF_FFFF_FFFF_FFFF, 64'h0);
        send_item(tgsv_pkg::OP_STAT,  64'h8000_0000_0000_0000, 64'h0);
        send_item(tgsv_pkg::OP_END,   {$urandom, $urandom},    {$urandom, $urandom});
        send_item(tgsv_pkg::OP_GROUP, 64'h5,                   64'h0);
        send_item(tgsv_pkg::OP_TERM,  64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(tgsv_pkg::OP_TERM,  64'h8000_0000_0000_0000, 64'h1);
        send_item(tgsv_pkg::OP_TERM,  64'h0,                   64'hFFFF_FFFF_FFFF_FFFF);
        send_item(tgsv_pkg::OP_TERM,  64'hFFFF_FFFF_FFFF_FFFF, 64'h40);
        send_item(tgsv_pkg::OP_GROUP, 64'hAAAA_AAAA_7FFF_FFFF, 64'h0);
        send_item(tgsv_pkg::OP_STAT,  64'd63,                  64'h0);
        send_item(tgsv_pkg::OP_STAT,  -64'sd64,                64'h0);
        send_item(tgsv_pkg::OP_STAT,  64'd64,                  64'h0);
        send_item(tgsv_pkg::OP_END,   64'h0,                   64'h0);
        send_item(tgsv_pkg::OP_GROUP, 64'h5555_5555_8000_0000, 64'h0);
        send_item(tgsv_pkg::OP_TERM,  64'd127,                 64'd64);
        send_item(tgsv_pkg::OP_END,   64'h0,                   64'h0);

        for (int phase = 1; phase <= 3; phase++)
        begin
            int unsigned target;
            case (phase)
                1:
                begin
                    src_idle_pct = 21;
                    snk_idle_pct = 75;
                end
                2:
                begin
                    src_idle_pct = 75;
                    snk_idle_pct = 21;
                end
                default:
                begin
                    src_idle_pct     = 0;
                    snk_idle_pct     = 0;
                    hold_off_pending = 1'b1;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(2'($urandom_range(0, 3)), {$urandom, $urandom},
                              {$urandom, $urandom});
                else
                    send_record();
            end
        end
        in_valid <= 1'b0;

        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/tgsv_pkg.sv
rtl/tgsv_front.sv
rtl/tgsv_queue.sv
rtl/tgsv_back.sv
rtl/term_group_stats_varint_encoder_unit.sv
verif/term_group_stats_varint_encoder_unit_tb.sv
